/* hw/rtl/satc_pkg.sv */
package satc_pkg;

   localparam int MaxVertsDefault = 16;
   localparam int CoordW = 24;
   localparam int AxisW  = 16;
   localparam int ProjW  = 41;
   localparam int OvW    = 43;
   localparam int DotW   = 42;

   typedef enum logic [2:0] {
      CMD_VERT_A = 3'd0,
      CMD_VERT_B = 3'd1,
      CMD_AXIS_A = 3'd2,
      CMD_AXIS_B = 3'd3,
      CMD_CTR_A  = 3'd4,
      CMD_CTR_B  = 3'd5,
      CMD_COMP   = 3'd6,
      CMD_NONE   = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_DROP  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_AXRD,
      S_VRD,
      S_VACC,
      S_AXEND,
      S_DOT,
      S_OUT
   } state_type;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
   } vert_type;

   typedef struct packed {
      logic signed [AxisW-1:0] x;
      logic signed [AxisW-1:0] y;
   } axis_type;

   typedef struct packed {
      logic                     collides;
      logic [1:0]               status;
      logic [23:0]              penetration;
      logic signed [AxisW-1:0]  normal_x;
      logic signed [AxisW-1:0]  normal_y;
   } rsp_type;

endpackage

/* hw/rtl/satc_if.sv */
interface satc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic signed [23:0] x;
   logic signed [23:0] y;
   modport source (output valid, cmd, x, y, input ready);
   modport sink   (input valid, cmd, x, y, output ready);
endinterface

interface satc_rsp_if;
   logic        valid;
   logic        ready;
   logic        collides;
   logic [1:0]  status;
   logic [23:0] penetration;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   modport source (output valid, collides, status, penetration, normal_x, normal_y,
                   input ready);
   modport sink   (input valid, collides, status, penetration, normal_x, normal_y,
                   output ready);
endinterface

/* hw/rtl/satc_store.sv */
// Four list memories: vertices A/B and axes A/B, one write port, one registered read each.
module satc_store #(
   parameter int MaxVerts = satc_pkg::MaxVertsDefault,
   localparam int AW = $clog2(MaxVerts)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [1:0]           wr_sel,
   input  logic [AW-1:0]        wr_addr,
   input  logic signed [23:0]   wr_x,
   input  logic signed [23:0]   wr_y,
   input  logic [AW-1:0]        va_addr,
   input  logic [AW-1:0]        vb_addr,
   input  logic [AW-1:0]        ax_addr,
   input  logic                 ax_side,
   output satc_pkg::vert_type   va_q,
   output satc_pkg::vert_type   vb_q,
   output satc_pkg::axis_type   ax_q
);
   import satc_pkg::*;

   vert_type mem_va [MaxVerts];
   vert_type mem_vb [MaxVerts];
   axis_type mem_aa [MaxVerts];
   axis_type mem_ab [MaxVerts];
   axis_type aa_q, ab_q;
   logic     side_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         case (wr_sel)
            2'd0: mem_va[wr_addr] <= '{x: wr_x, y: wr_y};
            2'd1: mem_vb[wr_addr] <= '{x: wr_x, y: wr_y};
            2'd2: mem_aa[wr_addr] <= '{x: wr_x[15:0], y: wr_y[15:0]};
            default: mem_ab[wr_addr] <= '{x: wr_x[15:0], y: wr_y[15:0]};
         endcase
      end
      va_q    <= mem_va[va_addr];
      vb_q    <= mem_vb[vb_addr];
      aa_q    <= mem_aa[ax_addr];
      ab_q    <= mem_ab[ax_addr];
      side_ff <= ax_side;
   end

   assign ax_q = side_ff ? ab_q : aa_q;
endmodule

/* hw/rtl/satc_proj.sv */
// Projection datapath: one vertex pair per cycle while en is high, combinational products, running min/max.
module satc_proj (
   input  logic                clock,
   input  logic                clr,
   input  logic                en,
   input  logic                use_a,
   input  logic                use_b,
   input  satc_pkg::vert_type  va,
   input  satc_pkg::vert_type  vb,
   input  satc_pkg::axis_type  ax,
   output logic signed [satc_pkg::OvW-1:0] overlap
);
   import satc_pkg::*;

   logic signed [ProjW-2:0] pax, pay, pbx, pby;
   logic signed [ProjW-1:0] pa, pb;
   logic signed [ProjW-1:0] mna_ff, mxa_ff, mnb_ff, mxb_ff;
   logic signed [ProjW-1:0] mna_in, mxa_in, mnb_in, mxb_in;
   logic                    have_a_ff, have_b_ff;
   logic signed [ProjW-1:0] hi, lo;

   // each 24x16 product fits 40 bits, their sum 41
   assign pax = va.x * ax.x;
   assign pay = va.y * ax.y;
   assign pbx = vb.x * ax.x;
   assign pby = vb.y * ax.y;
   assign pa  = ProjW'(pax) + ProjW'(pay);
   assign pb  = ProjW'(pbx) + ProjW'(pby);

   always_comb begin
      mna_in = mna_ff; mxa_in = mxa_ff; mnb_in = mnb_ff; mxb_in = mxb_ff;
      if (use_a) begin
         if (!have_a_ff || pa < mna_ff) mna_in = pa;
         if (!have_a_ff || pa > mxa_ff) mxa_in = pa;
      end
      if (use_b) begin
         if (!have_b_ff || pb < mnb_ff) mnb_in = pb;
         if (!have_b_ff || pb > mxb_ff) mxb_in = pb;
      end
   end

   always_ff @(posedge clock) begin
      if (clr) begin
         have_a_ff <= 1'b0;
         have_b_ff <= 1'b0;
      end else if (en) begin
         have_a_ff <= have_a_ff | use_a;
         have_b_ff <= have_b_ff | use_b;
         mna_ff <= mna_in; mxa_ff <= mxa_in;
         mnb_ff <= mnb_in; mxb_ff <= mxb_in;
      end
   end

   assign hi = (mxa_ff < mxb_ff) ? mxa_ff : mxb_ff;
   assign lo = (mna_ff > mnb_ff) ? mna_ff : mnb_ff;
   assign overlap = OvW'(hi) - OvW'(lo);
endmodule

/* hw/rtl/sat_polygon_collision_core.sv */
// Channel | dir | beat contents
// req     | in  | cmd, x, y (one load or a compute request)
// rsp     | out | collides, status, penetration, normal_x, normal_y
// Loads (cmd 0..5, and the ignored cmd 7) are accepted whenever the core is idle.
// A compute walks every axis of both axis lists, projecting both polygons on each; a separating
// axis ends the walk early and an empty list skips it; the single read port of each list
// memory sets the pace: one vertex pair is projected per cycle.
// Reset (synchronous, active high) clears the list counts, centres and drop flag;
// list memories are not cleared and need no sweep.
// A result not yet taken holds the next compute in its result cycle; loads wait while
// a compute runs.
module sat_polygon_collision_core #(
   parameter int MaxVerts = satc_pkg::MaxVertsDefault
) (
   input logic    clock,
   input logic    reset,
   satc_req_if.sink   req,
   satc_rsp_if.source rsp
);
   import satc_pkg::*;

   localparam int AW = $clog2(MaxVerts);
   localparam int CW = $clog2(MaxVerts + 1);

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff [4];
   logic          ovf_ff;
   logic signed [CoordW-1:0] cax_ff, cay_ff, cbx_ff, cby_ff;

   logic          side_ff;      // current axis list: 0 A, 1 B
   logic [CW-1:0] ai_ff;        // axis index
   logic [CW-1:0] vi_ff;        // vertex index issued to memory
   logic          have_ff, sep_ff;
   logic signed [OvW-1:0] best_ff;
   axis_type      bax_ff, cur_ax_ff;
   logic signed [DotW-1:0] dot_ff;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;

   logic          acc, load_ok, full, out_go;
   cmd_type       cmd;
   logic [1:0]    lsel;
   vert_type      va_q, vb_q;
   axis_type      ax_q;
   logic signed [OvW-1:0] overlap;
   logic          use_a_ff, use_b_ff, en_ff;
   logic [CW-1:0] na, vmax;
   logic          empty;
   logic signed [CoordW:0] dx, dy;
   logic signed [DotW-2:0] dpx, dpy;
   logic signed [AxisW-1:0] nnx, nny;

   assign cmd   = cmd_type'(req.cmd);
   assign req.ready = (state_ff == S_IDLE);
   assign acc   = req.valid && req.ready;
   assign lsel  = req.cmd[1:0];
   assign full  = cnt_ff[lsel] >= CW'(MaxVerts);
   assign load_ok = acc && (cmd == CMD_VERT_A || cmd == CMD_VERT_B ||
                    cmd == CMD_AXIS_A || cmd == CMD_AXIS_B);
   assign empty = (cnt_ff[0] == '0) || (cnt_ff[1] == '0) ||
                  (cnt_ff[2] == '0) || (cnt_ff[3] == '0);
   assign na    = side_ff ? cnt_ff[3] : cnt_ff[2];
   assign vmax  = (cnt_ff[0] > cnt_ff[1]) ? cnt_ff[0] : cnt_ff[1];
   // Leave the result cycle only once the output register is free
   assign out_go = (state_ff == S_OUT) && (!rsp_valid_ff || rsp.ready);

   satc_store #(.MaxVerts(MaxVerts)) u_store (
      .clock   (clock),
      .wr_en   (load_ok && !full),
      .wr_sel  (lsel),
      .wr_addr (cnt_ff[lsel][AW-1:0]),
      .wr_x    (req.x),
      .wr_y    (req.y),
      .va_addr (vi_ff[AW-1:0]),
      .vb_addr (vi_ff[AW-1:0]),
      .ax_addr (ai_ff[AW-1:0]),
      .ax_side (side_ff),
      .va_q    (va_q),
      .vb_q    (vb_q),
      .ax_q    (ax_q)
   );

   satc_proj u_proj (
      .clock   (clock),
      .clr     (state_ff == S_AXRD),
      .en      (en_ff),
      .use_a   (use_a_ff),
      .use_b   (use_b_ff),
      .va      (va_q),
      .vb      (vb_q),
      .ax      (cur_ax_ff),
      .overlap (overlap)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (acc && cmd == CMD_COMP) state_in = empty ? S_OUT : S_AXRD;
         S_AXRD:  state_in = S_VRD;
         S_VRD:   state_in = S_VACC;
         S_VACC:  if (vi_ff >= vmax) state_in = S_AXEND;
         S_AXEND: begin
            if (overlap <= 0) state_in = S_OUT;
            else if (ai_ff + 1'b1 < na || !side_ff) state_in = S_AXRD;
            else state_in = S_DOT;
         end
         S_DOT:   state_in = S_OUT;
         S_OUT:   if (out_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign dx  = (CoordW+1)'(cax_ff) - (CoordW+1)'(cbx_ff);
   assign dy  = (CoordW+1)'(cay_ff) - (CoordW+1)'(cby_ff);
   assign dpx = dx * bax_ff.x;
   assign dpy = dy * bax_ff.y;
   assign nnx = -bax_ff.x;
   assign nny = -bax_ff.y;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int k = 0; k < 4; k++) cnt_ff[k] <= '0;
         ovf_ff <= 1'b0;
         cax_ff <= '0; cay_ff <= '0; cbx_ff <= '0; cby_ff <= '0;
         rsp_valid_ff <= 1'b0;
         en_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         en_ff <= (state_ff == S_VRD) || (state_ff == S_VACC && vi_ff < vmax);
         if (out_go) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         if (load_ok) begin
            if (full) ovf_ff <= 1'b1;
            else cnt_ff[lsel] <= cnt_ff[lsel] + 1'b1;
         end
         if (acc && cmd == CMD_CTR_A) begin cax_ff <= req.x; cay_ff <= req.y; end
         if (acc && cmd == CMD_CTR_B) begin cbx_ff <= req.x; cby_ff <= req.y; end
         if (out_go) begin
            for (int k = 0; k < 4; k++) cnt_ff[k] <= '0;
            ovf_ff <= 1'b0;
         end
      end
   end

   // Sequencer datapath; no reset needed
   always_ff @(posedge clock) begin
      use_a_ff <= (vi_ff < cnt_ff[0]);
      use_b_ff <= (vi_ff < cnt_ff[1]);
      unique case (state_ff)
         S_IDLE: begin
            side_ff <= 1'b0; ai_ff <= '0; vi_ff <= '0;
            have_ff <= 1'b0; sep_ff <= 1'b0;
            // no empty-list skip is needed: an empty list goes straight to the result state
         end
         S_AXRD: vi_ff <= '0;                       // axis read issued
         S_VRD: begin
            cur_ax_ff <= ax_q;                      // hold axis for projection
            vi_ff <= vi_ff + 1'b1;
         end
         S_VACC: if (vi_ff < vmax) vi_ff <= vi_ff + 1'b1;
         S_AXEND: begin
            vi_ff <= '0;
            if (overlap <= 0) sep_ff <= 1'b1;
            else begin
               if (!have_ff || overlap < best_ff) begin
                  have_ff <= 1'b1; best_ff <= overlap; bax_ff <= cur_ax_ff;
               end
               if (ai_ff + 1'b1 < na) ai_ff <= ai_ff + 1'b1;
               else begin side_ff <= 1'b1; ai_ff <= '0; end
            end
         end
         S_DOT: dot_ff <= DotW'(dpx) + DotW'(dpy);
         S_OUT: if (out_go) begin
            rsp_ff.status <= empty ? ST_EMPTY : (ovf_ff ? ST_DROP : ST_OK);
            if (empty || sep_ff) begin
               rsp_ff.collides <= 1'b0; rsp_ff.penetration <= '0;
               rsp_ff.normal_x <= '0; rsp_ff.normal_y <= '0;
            end else begin
               rsp_ff.collides <= 1'b1;
               rsp_ff.penetration <= (best_ff[OvW-1:14] > 29'hFFFFFF) ? 24'hFFFFFF
                                     : best_ff[37:14];
               rsp_ff.normal_x <= (dot_ff >= 0) ? nnx : bax_ff.x;
               rsp_ff.normal_y <= (dot_ff >= 0) ? nny : bax_ff.y;
            end
         end
         default: ;
      endcase
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.collides    = rsp_ff.collides;
   assign rsp.status      = rsp_ff.status;
   assign rsp.penetration = rsp_ff.penetration;
   assign rsp.normal_x    = rsp_ff.normal_x;
   assign rsp.normal_y    = rsp_ff.normal_y;

`ifndef SYNTHESIS
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req.ready) else $error("ready while busy");
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[0] <= CW'(MaxVerts) && cnt_ff[3] <= CW'(MaxVerts)) else $error("count over");
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |=> rsp_valid_ff) else $error("result lost");
`endif
endmodule
